@@ design/signed_sum_target_counter_unit_defines.svh @@
// Assertion macros shared by the signed sum target counter RTL.
`ifndef SIGNED_SUM_TARGET_COUNTER_UNIT_DEFINES_SVH
`define SIGNED_SUM_TARGET_COUNTER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SSTC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define SSTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SSTC_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define SSTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ design/sstc_pkg.sv @@
// Shared types and constants of the signed sum target counter.
`timescale 1ns / 1ps
`default_nettype none
package sstc_pkg;

  localparam int COUNT_W  = 16;
  localparam int TARGET_W = 32;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SUM,
    ST_WALK,
    ST_DONE
  } state_t;

  // sequencer commands to the shared add/compare unit
  typedef struct packed {
    logic clear;    // zero sum and match count
    logic add;      // sum += element
    logic step;     // sum +/- 2 * element
    logic sub;      // direction of a step
    logic compare;  // count sum == target
  } ctrl_t;

endpackage
`default_nettype wire

@@ design/sstc_store.sv @@
// Generic RAM: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module sstc_store #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ design/sstc_datapath.sv @@
// Shared add/subtract and compare unit with target register and match counter.
`timescale 1ns / 1ps
`default_nettype none
module sstc_datapath
  import sstc_pkg::*;
#(
  parameter int VALUE_BITS = 16,
  parameter int SUM_W      = 21
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [TARGET_W-1:0]   cfg_data,
  input  wire ctrl_t                 ctrl,
  input  wire logic [VALUE_BITS-1:0] element,
  output logic      [COUNT_W-1:0]    count
);

  localparam int CMP_W = (SUM_W > TARGET_W) ? SUM_W : TARGET_W;

  logic signed [TARGET_W-1:0] target;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SUM_W-1:0]    sum_next;
  logic signed [SUM_W-1:0]    operand;
  logic signed [SUM_W-1:0]    twice;
  logic signed [CMP_W-1:0]    sum_ext;
  logic signed [CMP_W-1:0]    target_ext;
  logic                       hit;

  // target register
  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '0;
    end else if (cfg_write) begin
      target <= cfg_data;
    end
  end

  // sign extend the element; doubled form for gray steps
  assign operand = {{(SUM_W-VALUE_BITS){element[VALUE_BITS-1]}}, element};
  assign twice   = operand <<< 1;

  // the one adder
  always_comb begin
    sum_next = sum;
    priority if (ctrl.clear) begin
      sum_next = '0;
    end else if (ctrl.add) begin
      sum_next = sum + operand;
    end else if (ctrl.step) begin
      sum_next = ctrl.sub ? (sum - twice) : (sum + twice);
    end
  end

  always_ff @(posedge clk) begin
    sum <= sum_next;
  end

  // comparator against target
  assign sum_ext    = CMP_W'(sum);
  assign target_ext = CMP_W'(target);
  assign hit        = (sum_ext == target_ext);

  // saturating match counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.clear) begin
      count <= '0;
    end else if (ctrl.compare && hit && (count != COUNT_MAX)) begin
      count <= count + COUNT_W'(1);
    end
  end

endmodule
`default_nettype wire

@@ design/sstc_ctrl.sv @@
// Sequencer: list loading, initial sum pass and gray-code walk.
`timescale 1ns / 1ps
`default_nettype none
`include "signed_sum_target_counter_unit_defines.svh"
module sstc_ctrl
  import sstc_pkg::*;
#(
  parameter int MAX_ITEMS = 16,
  parameter int AW        = 4,
  parameter int CW        = 5
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  input  wire logic          last,
  output logic               item_stall,
  input  wire logic          result_valid,
  input  wire logic          result_stall,
  output logic               result_load,
  output logic               overflow,
  output logic               store_we,
  output logic [AW-1:0]      store_waddr,
  output logic [AW-1:0]      store_raddr,
  output ctrl_t              ctrl
);

  localparam int KW = (MAX_ITEMS > 1) ? (MAX_ITEMS - 1) : 1;

  state_t          state;
  state_t          state_next;
  logic [CW-1:0]   elem_count;
  logic [CW-1:0]   idx;
  logic [KW-1:0]   k;
  logic [KW-1:0]   k_inc;
  logic [KW-1:0]   gray;
  logic [KW-1:0]   last_k;
  logic [CW-1:0]   rest;
  logic [AW-1:0]   tz;
  logic [AW-1:0]   tz_ahead;
  logic            accept;
  logic            room;
  logic            sum_end;
  logic            walk_end;

  // index of the lowest set bit: the gray bit that flips next
  function automatic logic [AW-1:0] lowest_one(input logic [KW-1:0] v);
    logic [AW-1:0] r;
    r = '0;
    for (int i = KW - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = AW'(i);
      end
    end
    return r;
  endfunction

  assign accept   = item_valid && !item_stall;
  assign room     = (elem_count < CW'(MAX_ITEMS));
  assign rest     = elem_count - CW'(1);
  assign last_k   = (KW'(1) << rest) - KW'(1);
  assign k_inc    = k + KW'(1);
  assign tz       = lowest_one(k_inc);
  // bit flipped by the following step; its element is fetched in the cycle before that step
  assign tz_ahead = lowest_one(k + KW'(2));
  assign sum_end  = (idx == elem_count);
  assign walk_end = (k == last_k);

  // handshake and store ports; the sum pass adds in the cycle after its read
  assign item_stall  = (state != ST_LOAD);
  assign store_we    = accept && room;
  assign store_waddr = elem_count[AW-1:0];
  assign store_raddr = (state == ST_SUM) ? (sum_end ? AW'(1) : idx[AW-1:0])
                                         : (tz_ahead + AW'(1));
  assign result_load = (state == ST_DONE) && (!result_valid || !result_stall);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (accept && last) state_next = ST_SUM;
      end
      ST_SUM: begin
        if (sum_end) state_next = ST_WALK;
      end
      ST_WALK: begin
        if (walk_end) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (result_load) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // commands to the shared unit
  always_comb begin
    ctrl = '0;
    unique case (state)
      ST_LOAD: begin
        ctrl.clear = accept && last;
      end
      ST_SUM: begin
        ctrl.add = (idx != '0);
      end
      ST_WALK: begin
        ctrl.compare = 1'b1;
        ctrl.step    = !walk_end;
        ctrl.sub     = !gray[tz];
      end
      ST_DONE: begin
        ctrl = '0;
      end
      default: ctrl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // list fill and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      elem_count <= '0;
      overflow   <= 1'b0;
    end else if (result_load) begin
      elem_count <= '0;
      overflow   <= 1'b0;
    end else if (accept) begin
      if (room) begin
        elem_count <= elem_count + CW'(1);
      end else begin
        overflow <= 1'b1;
      end
    end
  end

  // pass counters
  always_ff @(posedge clk) begin
    if (rst) begin
      idx  <= '0;
      k    <= '0;
      gray <= '0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          idx  <= '0;
          k    <= '0;
          gray <= '0;
        end
        ST_SUM: begin
          idx <= idx + CW'(1);
        end
        ST_WALK: begin
          if (!walk_end) begin
            k        <= k_inc;
            gray[tz] <= !gray[tz];
          end
        end
        ST_DONE: begin
          idx <= '0;
        end
        default: idx <= '0;
      endcase
    end
  end

  `SSTC_ASSERT_NOW(a_walk_has_elems, clk, rst, state == ST_WALK, elem_count != '0, "walk with empty list")
  `SSTC_ASSERT_NOW(a_sum_in_range, clk, rst, state == ST_SUM, idx <= elem_count, "sum index past list")
  `SSTC_ASSERT_NEXT(a_done_waits, clk, rst, state == ST_DONE && !result_load, state == ST_DONE, "result dropped")
  `SSTC_ASSERT_NOW(a_fill_bound, clk, rst, 1'b1, elem_count <= CW'(MAX_ITEMS), "fill count over depth")

endmodule
`default_nettype wire

@@ design/signed_sum_target_counter_unit.sv @@
// Top level of the signed sum target counter.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+---------------------------
//  item     | item_valid / item_stall  | value, last
//  result   | result_valid/result_stall| match_count, too_many
//  config   | cfg_write                | cfg_data (target)
//
// Loading accepts one element per cycle. After the last transfer the shared adder
// sums the n held elements (registered store read), walks the 2**(n-1) sign
// patterns in gray order, one per cycle, and posts the match count to the result
// register; the input is stalled meanwhile.
// Reset clears the sequencer, fill count, overflow flag, count and target.
// A result waits in the output register; the next list loads, its post waits.
`timescale 1ns / 1ps
`default_nettype none
module signed_sum_target_counter_unit
  import sstc_pkg::*;
#(
  parameter int MAX_ITEMS  = 16,
  parameter int VALUE_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [TARGET_W-1:0]   cfg_data,
  input  wire logic                  item_valid,
  output logic                       item_stall,
  input  wire logic [VALUE_BITS-1:0] value,
  input  wire logic                  last,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output logic [COUNT_W-1:0]         match_count,
  output logic                       too_many
);

  localparam int AW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW    = $clog2(MAX_ITEMS + 1);
  localparam int SUM_W = VALUE_BITS + $clog2(MAX_ITEMS) + 1;

  ctrl_t                 ctrl;
  logic                  result_load;
  logic                  overflow;
  logic                  store_we;
  logic [AW-1:0]         store_waddr;
  logic [AW-1:0]         store_raddr;
  logic [VALUE_BITS-1:0] element;
  logic [COUNT_W-1:0]    count;

  sstc_ctrl #(
    .MAX_ITEMS (MAX_ITEMS),
    .AW        (AW),
    .CW        (CW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .last         (last),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_load  (result_load),
    .overflow     (overflow),
    .store_we     (store_we),
    .store_waddr  (store_waddr),
    .store_raddr  (store_raddr),
    .ctrl         (ctrl)
  );

  sstc_store #(
    .DEPTH (MAX_ITEMS),
    .WIDTH (VALUE_BITS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (value),
    .raddr (store_raddr),
    .rdata (element)
  );

  sstc_datapath #(
    .VALUE_BITS (VALUE_BITS),
    .SUM_W      (SUM_W)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .ctrl      (ctrl),
    .element   (element),
    .count     (count)
  );

  // result output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      match_count <= count;
      too_many    <= overflow;
    end
  end

endmodule
`default_nettype wire
